### sv/four_level_page_map_builder_defines.svh
// Assertion macros for the four-level page map builder.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef FOUR_LEVEL_PAGE_MAP_BUILDER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_MAP_BUILDER_DEFINES_SVH
`ifndef SYNTH
`define FLPMB_ASSERT_NEVER(name, clk, rst, cond) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("flpmb check failed: forbidden condition");
`define FLPMB_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flpmb check failed: implication");
`define FLPMB_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flpmb check failed: next-cycle implication");
`else
`define FLPMB_ASSERT_NEVER(name, clk, rst, cond)
`define FLPMB_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define FLPMB_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

### sv/flpmb_pkg.sv
// Shared types, constants and helpers for the four-level page map builder.
// No dependencies.
package flpmb_pkg;

  localparam int IDX_W   = 9;
  localparam int VPN_W   = 36;
  localparam int FRAME_W = 40;
  localparam int ENTRY_W = 64;

  localparam logic [1:0] LEVEL_LAST = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_LEAF
  } walk_state_t;

  typedef struct packed {
    logic               done;
    logic               status;
    logic [1:0]         new_tables;
    logic [ENTRY_W-1:0] leaf_entry;
  } walk_result_t;

  function automatic logic [ENTRY_W-1:0] make_entry(input logic [FRAME_W-1:0] frame);
    make_entry = {12'h000, frame, 12'h003};
  endfunction

  function automatic logic [IDX_W-1:0] level_index(input logic [VPN_W-1:0] vpn,
                                                   input logic [1:0] level);
    logic [IDX_W-1:0] idx;
    unique case (level)
      2'd0:    idx = vpn[35:27];
      2'd1:    idx = vpn[26:18];
      2'd2:    idx = vpn[17:9];
      default: idx = vpn[8:0];
    endcase
    level_index = idx;
  endfunction

endpackage

### sv/flpmb_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module flpmb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

### sv/flpmb_walk.sv
// Table walk sequencer: clears the table store, then walks and fills it per request.
// Depends on flpmb_pkg; drives one flpmb_ram port.
module flpmb_walk
  import flpmb_pkg::*;
#(
  parameter int TABLE_PAGES = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [VPN_W-1:0]                     vpn,
  input  logic [FRAME_W-1:0]                   frame,
  input  logic [FRAME_W-1:0]                   base,
  output logic                                 busy,
  output walk_result_t                         result,
  output logic                                 ram_we,
  output logic [$clog2(TABLE_PAGES)+IDX_W-1:0] ram_addr,
  output logic [ENTRY_W-1:0]                   ram_wdata,
  input  logic [ENTRY_W-1:0]                   ram_rdata
);

  localparam int PW    = $clog2(TABLE_PAGES);
  localparam int NW    = $clog2(TABLE_PAGES + 1);
  localparam int AW    = PW + IDX_W;
  localparam int DEPTH = TABLE_PAGES * (2 ** IDX_W);

  walk_state_t        state, state_next;
  logic [VPN_W-1:0]   vpn_q, vpn_next;
  logic [FRAME_W-1:0] frame_q, frame_next;
  logic [PW-1:0]      page, page_next;
  logic [1:0]         level, level_next;
  logic [1:0]         created, created_next;
  logic [NW-1:0]      next_free, next_free_next;
  logic [AW-1:0]      clr_addr, clr_addr_next;
  walk_result_t       result_next;

  logic [FRAME_W-1:0] rel;
  logic               present;
  logic               rel_ok;
  logic               pool_ok;

  assign present = ram_rdata[0];
  assign rel     = ram_rdata[51:12] - base;
  assign rel_ok  = rel < FRAME_W'(TABLE_PAGES);
  assign pool_ok = next_free < NW'(TABLE_PAGES);
  assign busy    = state != ST_IDLE;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      next_free   <= NW'(1);
      result.done <= 1'b0;
    end else begin
      state       <= state_next;
      clr_addr    <= clr_addr_next;
      next_free   <= next_free_next;
      result.done <= result_next.done;
    end
    vpn_q             <= vpn_next;
    frame_q           <= frame_next;
    page              <= page_next;
    level             <= level_next;
    created           <= created_next;
    result.status     <= result_next.status;
    result.new_tables <= result_next.new_tables;
    result.leaf_entry <= result_next.leaf_entry;
  end

  always_comb begin
    state_next     = state;
    vpn_next       = vpn_q;
    frame_next     = frame_q;
    page_next      = page;
    level_next     = level;
    created_next   = created;
    next_free_next = next_free;
    clr_addr_next  = clr_addr;
    result_next    = result;
    result_next.done = 1'b0;
    ram_we         = 1'b0;
    ram_addr       = {page, level_index(vpn_q, level)};
    ram_wdata      = '0;

    unique case (state)
      ST_CLEAR: begin
        ram_we        = 1'b1;
        ram_addr      = clr_addr;
        clr_addr_next = clr_addr + AW'(1);
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          vpn_next     = vpn;
          frame_next   = frame;
          page_next    = '0;
          level_next   = '0;
          created_next = '0;
          state_next   = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (present ? !rel_ok : !pool_ok) begin
          result_next.done       = 1'b1;
          result_next.status     = 1'b1;
          result_next.new_tables = created;
          result_next.leaf_entry = '0;
          state_next             = ST_IDLE;
        end else begin
          if (present) begin
            page_next = rel[PW-1:0];
          end else begin
            ram_we         = 1'b1;
            ram_wdata      = make_entry(base + FRAME_W'(next_free));
            page_next      = next_free[PW-1:0];
            next_free_next = next_free + NW'(1);
            created_next   = created + 2'd1;
          end
          level_next = level + 2'd1;
          state_next = (level == LEVEL_LAST) ? ST_LEAF : ST_READ;
        end
      end
      ST_LEAF: begin
        ram_we                 = 1'b1;
        ram_wdata              = make_entry(frame_q);
        result_next.done       = 1'b1;
        result_next.status     = 1'b0;
        result_next.new_tables = created;
        result_next.leaf_entry = make_entry(frame_q);
        state_next             = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/four_level_page_map_builder.sv
// Each directory level reads the table store and then checks the entry; the leaf write
// follows the last level, and an error ends the walk early. One request at a time: a
// new start is accepted in the cycle that done is high.
// The single table store port is read at each level, written when a table is created.
// Reset (rst, synchronous) sweeps all TABLE_PAGES*512 table store entries to zero,
// with busy high; table_base_frame resets to 0. done pulses one cycle, no stall.
`include "four_level_page_map_builder_defines.svh"
module four_level_page_map_builder
  import flpmb_pkg::*;
#(
  parameter int TABLE_PAGES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [VPN_W-1:0]   virtual_page,
  input  logic [FRAME_W-1:0] physical_frame,
  input  logic               cfg_write,
  input  logic [FRAME_W-1:0] cfg_data,
  output logic               done,
  output logic               status,
  output logic [1:0]         new_tables,
  output logic [ENTRY_W-1:0] leaf_entry
);

  localparam int AW    = $clog2(TABLE_PAGES) + IDX_W;
  localparam int DEPTH = TABLE_PAGES * (2 ** IDX_W);

  logic [FRAME_W-1:0] table_base_frame;
  walk_result_t       result;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_base_frame <= '0;
    end else if (cfg_write) begin
      table_base_frame <= cfg_data;
    end
  end

  flpmb_walk #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_walk (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .vpn      (virtual_page),
    .frame    (physical_frame),
    .base     (table_base_frame),
    .busy     (busy),
    .result   (result),
    .ram_we   (ram_we),
    .ram_addr (ram_addr),
    .ram_wdata(ram_wdata),
    .ram_rdata(ram_rdata)
  );

  flpmb_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_table_store (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign done       = result.done;
  assign status     = result.status;
  assign new_tables = result.new_tables;
  assign leaf_entry = result.leaf_entry;

  `FLPMB_ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy)
  `FLPMB_ASSERT_IMPLY(a_error_no_leaf, clk, rst, done && status, leaf_entry == '0)
  `FLPMB_ASSERT_IMPLY(a_leaf_flags, clk, rst, done && !status, leaf_entry[1:0] == 2'b11)
  `FLPMB_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy && !done)

endmodule

### tb/tb_four_level_page_map_builder.sv
// Testbench for four_level_page_map_builder: directed and random map requests,
// checked against a behavioral copy of the four-level table walk and pool.
// Depends on flpmb_pkg and the block itself; self-contained otherwise.
module tb_four_level_page_map_builder
  import flpmb_pkg::*;
();

  localparam int POOL_PAGES      = 64;
  localparam int TABLE_ENTRIES   = 512;
  localparam int SETTLE_CYCLES   = 12;
  localparam int DRAIN_CYCLES    = 20;
  localparam int WATCHDOG_LIMIT  = 4 * POOL_PAGES * TABLE_ENTRIES + 2000;
  localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};
  localparam logic [VPN_W-1:0]   VPN_MAX   = {VPN_W{1'b1}};

  typedef struct packed {
    logic               status;
    logic [1:0]         new_tables;
    logic [ENTRY_W-1:0] leaf_entry;
  } map_outcome_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [VPN_W-1:0]   virtual_page;
  logic [FRAME_W-1:0] physical_frame;
  logic               cfg_write;
  logic [FRAME_W-1:0] cfg_data;
  logic               done;
  logic               status;
  logic [1:0]         new_tables;
  logic [ENTRY_W-1:0] leaf_entry;

  bit [ENTRY_W-1:0]   table_mem [POOL_PAGES*TABLE_ENTRIES];
  int                 free_page;
  logic [FRAME_W-1:0] base_frame;

  map_outcome_t       pending_maps[$];
  logic [VPN_W-1:0]   known_vpns[$];
  map_outcome_t       want_map;
  int                 mismatches;
  int                 burst_left;
  int                 quiet_cycles;

  four_level_page_map_builder #(
    .TABLE_PAGES(POOL_PAGES)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .virtual_page  (virtual_page),
    .physical_frame(physical_frame),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .done          (done),
    .status        (status),
    .new_tables    (new_tables),
    .leaf_entry    (leaf_entry)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void predict_map(input logic [VPN_W-1:0] vpn,
                                      input logic [FRAME_W-1:0] frame,
                                      output map_outcome_t outcome);
    int                 page;
    int                 created;
    int                 slot;
    int                 lvl;
    logic [IDX_W-1:0]   idx;
    logic [ENTRY_W-1:0] ent;
    logic [FRAME_W-1:0] rel;
    logic [FRAME_W-1:0] dir_frame;
    bit                 failed;
    page    = 0;
    created = 0;
    failed  = 1'b0;
    for (lvl = 0; lvl < 3 && !failed; lvl++) begin
      idx  = IDX_W'(vpn >> (27 - 9 * lvl));
      slot = page * TABLE_ENTRIES + idx;
      ent  = table_mem[slot];
      if (!ent[0]) begin
        if (free_page >= POOL_PAGES) begin
          failed = 1'b1;
        end else begin
          page = free_page;
          free_page++;
          created++;
          dir_frame = base_frame + page;
          table_mem[slot] = {12'h000, dir_frame, 12'h003};
        end
      end else begin
        rel = ent[51:12] - base_frame;
        if (rel >= POOL_PAGES) failed = 1'b1;
        else page = int'(rel);
      end
    end
    outcome.status     = failed;
    outcome.new_tables = created[1:0];
    outcome.leaf_entry = '0;
    if (!failed) begin
      outcome.leaf_entry = {12'h000, frame, 12'h003};
      table_mem[page * TABLE_ENTRIES + vpn[IDX_W-1:0]] = outcome.leaf_entry;
    end
  endfunction

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20) : $urandom_range(1, 3);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(0, 20);
    end
  endtask

  task automatic send_request(input logic [VPN_W-1:0] vpn,
                              input logic [FRAME_W-1:0] frame,
                              output map_outcome_t outcome);
    @(negedge clk);
    virtual_page   = vpn;
    physical_frame = frame;
    start          = 1'b1;
    do @(posedge clk); while (busy);
    predict_map(vpn, frame, outcome);
    pending_maps.push_back(outcome);
    known_vpns.push_back(vpn);
    pace();
  endtask

  task automatic set_base(input logic [FRAME_W-1:0] value);
    @(negedge clk);
    start = 1'b0;
    while (pending_maps.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data  = value;
    @(negedge clk);
    cfg_write  = 1'b0;
    base_frame = value;
  endtask

  function automatic logic [FRAME_W-1:0] random_frame();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return FRAME_MAX;
      default: return raw[FRAME_W-1:0];
    endcase
  endfunction

  function automatic logic [VPN_W-1:0] random_vpn();
    logic [63:0]      raw;
    logic [VPN_W-1:0] fresh;
    logic [VPN_W-1:0] prior;
    int               pick;
    raw   = {$urandom, $urandom};
    fresh = raw[VPN_W-1:0];
    if (known_vpns.size() == 0) return fresh;
    prior = known_vpns[$urandom_range(0, known_vpns.size() - 1)];
    pick  = $urandom_range(0, 99);
    if (pick < 8)  return fresh;
    if (pick < 16) return {prior[35:27], fresh[26:0]};
    if (pick < 28) return {prior[35:18], fresh[17:0]};
    if (pick < 65) return {prior[35:9], fresh[8:0]};
    return prior;
  endfunction

  task automatic test_directed_extremes();
    map_outcome_t o;
    set_base(FRAME_MAX);
    send_request('0, '0, o);
    send_request(VPN_MAX, FRAME_MAX, o);
    send_request('0, 40'h5a5a_c3c3_f0, o);
    send_request({9'h000, 9'h1ff, 18'h0}, 40'h00_0000_0001, o);
    send_request({9'h000, 9'h000, 9'h1ff, 9'h000}, 40'h80_0000_0000, o);
    send_request({VPN_MAX[35:9], 9'h000}, 40'h7f_ffff_ffff, o);
    send_request(36'h5_5555_5555, 40'h55_5555_5555, o);
    send_request(36'ha_aaaa_aaaa, 40'haa_aaaa_aaaa, o);
    send_request(VPN_MAX, '0, o);
  endtask

  task automatic test_stray_pointer();
    logic [63:0]  raw;
    map_outcome_t o;
    set_base('0);
    send_request('0, 40'h12_3456_789a, o);
    send_request(VPN_MAX, 40'h00_0000_0fff, o);
    set_base(40'd100);
    send_request('0, 40'h01_0203_0405, o);
    send_request({9'h0aa, 27'h0}, 40'h0f_0f0f_0f0f, o);
    send_request({9'h0aa, 27'h1}, 40'hf0_f0f0_f0f0, o);
    raw = {$urandom, $urandom};
    set_base(raw[FRAME_W-1:0]);
    send_request({9'h000, 9'h1ff, 18'h3}, random_frame(), o);
    send_request({9'h0aa, 27'h2}, random_frame(), o);
  endtask

  task automatic test_random_mapping(input int count);
    map_outcome_t o;
    repeat (count) send_request(random_vpn(), random_frame(), o);
  endtask

  task automatic test_pool_exhaustion();
    logic [63:0]  raw;
    map_outcome_t o;
    for (int n = 0; n < 40; n++) begin
      raw = {$urandom, $urandom};
      send_request(raw[VPN_W-1:0], random_frame(), o);
      if (o.status && o.new_tables == 2'd0) break;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_maps.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want_map = pending_maps.pop_front();
        if (status !== want_map.status) begin
          $error("status: expected %0d, got %0d", want_map.status, status);
          mismatches++;
        end
        if (new_tables !== want_map.new_tables) begin
          $error("new_tables: expected %0d, got %0d", want_map.new_tables, new_tables);
          mismatches++;
        end
        if (leaf_entry !== want_map.leaf_entry) begin
          $error("leaf_entry: expected %h, got %h", want_map.leaf_entry, leaf_entry);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || cfg_write) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_four_level_page_map_builder: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst            = 1'b1;
    start          = 1'b0;
    virtual_page   = '0;
    physical_frame = '0;
    cfg_write      = 1'b0;
    cfg_data       = '0;
    free_page      = 1;
    base_frame     = '0;
    mismatches     = 0;
    burst_left     = 0;
    quiet_cycles   = 0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    test_directed_extremes();
    test_stray_pointer();
    set_base(FRAME_MAX);
    test_random_mapping(230);
    test_pool_exhaustion();
    set_base('0);
    test_random_mapping(100);
    set_base(FRAME_MAX);
    test_random_mapping(150);

    @(negedge clk);
    start = 1'b0;
    while (pending_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_four_level_page_map_builder: PASS");
    end else begin
      $display("tb_four_level_page_map_builder: FAIL");
    end
    $finish;
  end

endmodule
